// File: sv/ctks_pkg.sv
// Package for the capacitive touch keys and slider unit.
// Shared types, codes and default sizes; no dependencies.
package ctks_pkg;

    // Default sizes
    localparam int NUM_KEYS_DEF     = 3;
    localparam int NUM_SEGMENTS_DEF = 5;
    localparam int COUNT_BITS_DEF   = 16;

    // Fixed field widths
    localparam int REQ_W    = 2;
    localparam int LINES_W  = 8;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int KEYS_W   = 3;
    localparam int SLIDER_W = 4;

    // Register reset values
    localparam logic [CFG_W-1:0] CHARGE_TICKS_RST = 16'd1000;
    localparam logic [CFG_W-1:0] ERROR_RANGE_RST  = 16'd1;
    localparam logic [CFG_W-1:0] MAX_COUNT_RST    = 16'd65535;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_TICK    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_MEASURE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CALIB   = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_RANGE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_COUNT    = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_CHARGE,
        PH_DISCHARGE
    } t_phase;

    // Per-cycle control from sequencer to the channel cells
    typedef struct packed {
        logic clear;    // first discharge tick follows: zero counts, arm all
        logic step;     // discharge tick: count lines still high
        logic commit;   // calibrate scan ends: latch counts as baselines
    } t_cell_ctl;

endpackage

// File: sv/cap_touch_keys_and_slider_unit.sv
// Top level of the capacitive touch keys and slider unit.
// Depends on ctks_pkg, ctks_chan, ctks_eval.
//
//  channel  direction  handshake                 word
//  in       sink       i_in_valid / o_in_ready   i_req_type, i_sense_lines
//  out      source     o_out_valid / i_out_ready o_load_drive .. o_slider_pos
//  cfg      sink       i_cfg_we (no wait)        i_cfg_idx, i_cfg_wdata
//
// One input word is one tick of the sensing time base; every word yields one
// output word. A word is held in the input register, and its result is loaded
// into the output register as the word advances: one word per cycle, while
// the output is not stalled. Both stages advance together when the output
// register is free or being taken. Reset (synchronous, active low) returns
// the sequencer to idle, clears counts, baselines and both stage valids, and
// loads the register defaults.
module cap_touch_keys_and_slider_unit #(
    parameter int NUM_KEYS     = ctks_pkg::NUM_KEYS_DEF,
    parameter int NUM_SEGMENTS = ctks_pkg::NUM_SEGMENTS_DEF,
    parameter int COUNT_BITS   = ctks_pkg::COUNT_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input words
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [ctks_pkg::REQ_W-1:0]       i_req_type,
    input  logic [ctks_pkg::LINES_W-1:0]     i_sense_lines,
    // result words
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_load_drive,
    output logic                             o_busy_res,
    output logic                             o_result_valid,
    output logic                             o_calib_done,
    output logic [ctks_pkg::KEYS_W-1:0]      o_key_flags,
    output logic [ctks_pkg::SLIDER_W-1:0]    o_slider_pos,
    // register writes
    input  logic                             i_cfg_we,
    input  logic [ctks_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ctks_pkg::CFG_W-1:0]       i_cfg_wdata
);
    localparam int NUM_CH = NUM_KEYS + NUM_SEGMENTS;
    localparam int LIM_W  = (COUNT_BITS > ctks_pkg::CFG_W) ? COUNT_BITS : ctks_pkg::CFG_W;

    // ---------------- registers ----------------
    logic [ctks_pkg::CFG_W-1:0] r_charge_ticks;
    logic [ctks_pkg::CFG_W-1:0] r_err_range;
    logic [ctks_pkg::CFG_W-1:0] r_max_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_charge_ticks <= ctks_pkg::CHARGE_TICKS_RST;
            r_err_range    <= ctks_pkg::ERROR_RANGE_RST;
            r_max_count    <= ctks_pkg::MAX_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ctks_pkg::CFG_CHARGE_TICKS: r_charge_ticks <= i_cfg_wdata;
                ctks_pkg::CFG_ERROR_RANGE:  r_err_range    <= i_cfg_wdata;
                ctks_pkg::CFG_MAX_COUNT:    r_max_count    <= i_cfg_wdata;
                default: ;  // unmapped index: dropped
            endcase
        end
    end

    // Count limit: max_count clipped to what a counter can hold
    logic [LIM_W-1:0]      lim_cfg;
    logic [LIM_W-1:0]      lim_cap;
    logic [COUNT_BITS-1:0] limit;

    assign lim_cfg = LIM_W'(r_max_count);
    assign lim_cap = LIM_W'({COUNT_BITS{1'b1}});
    assign limit   = (lim_cfg < lim_cap) ? lim_cfg[COUNT_BITS-1:0] : lim_cap[COUNT_BITS-1:0];

    // Zero charge time behaves as one tick
    logic [ctks_pkg::CFG_W-1:0] charge_target;
    assign charge_target = (r_charge_ticks == '0) ? ctks_pkg::CFG_W'(1) : r_charge_ticks;

    // ---------------- pipeline handshake ----------------
    logic                         r_in_valid;
    logic [ctks_pkg::REQ_W-1:0]   r_req;
    logic [ctks_pkg::LINES_W-1:0] r_lines;
    logic                         r_out_valid;
    logic                         out_free;
    logic                         adv;      // input-register word is processed this edge

    assign out_free    = !r_out_valid || i_out_ready;
    assign adv         = r_in_valid && out_free;
    assign o_in_ready  = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_req   <= i_req_type;
            r_lines <= i_sense_lines;
        end
    end

    // ---------------- scan sequencer ----------------
    ctks_pkg::t_phase           r_phase;
    ctks_pkg::t_phase           n_phase;
    logic                       r_is_cal;
    logic [ctks_pkg::CFG_W-1:0] r_chg_cnt;
    logic [ctks_pkg::CFG_W-1:0] chg_next;
    logic                       start;
    logic                       charging;
    logic                       charge_done;
    logic                       scan_end;
    logic [NUM_CH-1:0]          run_next;
    logic [NUM_CH-1:0]          active;
    ctks_pkg::t_cell_ctl        cell_ctl;

    // Requests while a scan runs are ignored; code 3 is a plain tick
    assign start = (r_phase == ctks_pkg::PH_IDLE) &&
                   ((r_req == ctks_pkg::REQ_MEASURE) || (r_req == ctks_pkg::REQ_CALIB));
    assign charging    = start || (r_phase == ctks_pkg::PH_CHARGE);
    assign chg_next    = start ? ctks_pkg::CFG_W'(1) : (r_chg_cnt + 1'b1);
    assign charge_done = charging && (chg_next >= charge_target);
    // no channel still counting after this discharge tick
    assign scan_end    = (r_phase == ctks_pkg::PH_DISCHARGE) && (run_next == '0);

    // next state
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            ctks_pkg::PH_IDLE: begin
                if (start) begin
                    n_phase = charge_done ? ctks_pkg::PH_DISCHARGE : ctks_pkg::PH_CHARGE;
                end
            end
            ctks_pkg::PH_CHARGE: begin
                if (charge_done) begin
                    n_phase = ctks_pkg::PH_DISCHARGE;
                end
            end
            ctks_pkg::PH_DISCHARGE: begin
                if (scan_end) begin
                    n_phase = ctks_pkg::PH_IDLE;
                end
            end
            default: n_phase = ctks_pkg::PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= ctks_pkg::PH_IDLE;
            r_is_cal  <= 1'b0;
            r_chg_cnt <= '0;
        end else if (adv) begin
            r_phase <= n_phase;
            if (start) begin
                r_is_cal <= (r_req == ctks_pkg::REQ_CALIB);
            end
            if (charging) begin
                r_chg_cnt <= chg_next;
            end
        end
    end

    // cell controls, gated by the pipeline advance
    always_comb begin
        cell_ctl.clear  = adv && charge_done;
        cell_ctl.step   = adv && (r_phase == ctks_pkg::PH_DISCHARGE);
        cell_ctl.commit = adv && scan_end && r_is_cal;
    end

    // ---------------- channel cells ----------------
    for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
        logic sense;
        if (c < ctks_pkg::LINES_W) begin : g_line
            assign sense = r_lines[c];
        end else begin : g_none
            assign sense = 1'b0;    // no sense pin: reads low
        end

        ctks_chan #(
            .COUNT_BITS (COUNT_BITS)
        ) u_chan (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (cell_ctl),
            .i_sense     (sense),
            .i_limit     (limit),
            .i_err_range (r_err_range),
            .o_run_next  (run_next[c]),
            .o_active    (active[c])
        );
    end

    logic [ctks_pkg::KEYS_W-1:0]   keys;
    logic [ctks_pkg::SLIDER_W-1:0] slider;

    ctks_eval #(
        .NUM_KEYS     (NUM_KEYS),
        .NUM_SEGMENTS (NUM_SEGMENTS)
    ) u_eval (
        .i_active (active),
        .o_keys   (keys),
        .o_slider (slider)
    );

    // ---------------- result word ----------------
    logic                          n_load;
    logic                          n_busy;
    logic                          n_rvalid;
    logic                          n_cdone;
    logic [ctks_pkg::KEYS_W-1:0]   n_keys;
    logic [ctks_pkg::SLIDER_W-1:0] n_slider;

    // outputs
    always_comb begin
        n_load   = charging;
        n_busy   = charging || ((r_phase == ctks_pkg::PH_DISCHARGE) && !scan_end);
        n_rvalid = scan_end && !r_is_cal;
        n_cdone  = scan_end && r_is_cal;
        n_keys   = n_rvalid ? keys : '0;
        n_slider = n_rvalid ? slider : '0;
    end

    logic                          r_load;
    logic                          r_busy;
    logic                          r_rvalid;
    logic                          r_cdone;
    logic [ctks_pkg::KEYS_W-1:0]   r_keys;
    logic [ctks_pkg::SLIDER_W-1:0] r_slider;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_load   <= n_load;
            r_busy   <= n_busy;
            r_rvalid <= n_rvalid;
            r_cdone  <= n_cdone;
            r_keys   <= n_keys;
            r_slider <= n_slider;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_load_drive   = r_load;
    assign o_busy_res     = r_busy;
    assign o_result_valid = r_rvalid;
    assign o_calib_done   = r_cdone;
    assign o_key_flags    = r_keys;
    assign o_slider_pos   = r_slider;
endmodule

// File: sv/ctks_chan.sv
// One sense channel: discharge counter, running flag and baseline.
// Depends on ctks_pkg.
module ctks_chan #(
    parameter int COUNT_BITS = ctks_pkg::COUNT_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  ctks_pkg::t_cell_ctl      i_ctl,
    input  logic                     i_sense,
    input  logic [COUNT_BITS-1:0]    i_limit,
    input  logic [ctks_pkg::CFG_W-1:0] i_err_range,
    output logic                     o_run_next,
    output logic                     o_active
);
    localparam int SUM_W = ((COUNT_BITS > ctks_pkg::CFG_W) ? COUNT_BITS : ctks_pkg::CFG_W) + 1;

    logic [COUNT_BITS-1:0] r_cnt;
    logic [COUNT_BITS-1:0] n_cnt;
    logic [COUNT_BITS-1:0] r_base;
    logic                  r_run;
    logic                  n_run;
    logic [SUM_W-1:0]      thresh;

    always_comb begin
        n_cnt = r_cnt;
        n_run = r_run;
        if (i_ctl.clear) begin
            n_cnt = '0;
            n_run = 1'b1;
        end else if (i_ctl.step && r_run) begin
            if (i_sense && (r_cnt < i_limit)) begin
                n_cnt = r_cnt + 1'b1;
            end
            n_run = i_sense && (n_cnt < i_limit);
        end
    end

    assign o_run_next = n_run;
    assign thresh     = SUM_W'(r_base) + SUM_W'(i_err_range);
    assign o_active   = SUM_W'(n_cnt) > thresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_run  <= 1'b0;
            r_base <= '0;
        end else begin
            r_cnt <= n_cnt;
            r_run <= n_run;
            if (i_ctl.commit) begin
                r_base <= n_cnt;
            end
        end
    end
endmodule

// File: sv/ctks_eval.sv
// Decodes channel activity into key flags and slider position.
// Depends on ctks_pkg.
module ctks_eval #(
    parameter int NUM_KEYS     = ctks_pkg::NUM_KEYS_DEF,
    parameter int NUM_SEGMENTS = ctks_pkg::NUM_SEGMENTS_DEF
) (
    input  logic [NUM_KEYS+NUM_SEGMENTS-1:0] i_active,
    output logic [ctks_pkg::KEYS_W-1:0]      o_keys,
    output logic [ctks_pkg::SLIDER_W-1:0]    o_slider
);
    localparam int IDX_W = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;
    localparam int POP_W = $clog2(NUM_SEGMENTS + 1);
    localparam int POS_W = IDX_W + 2 + POP_W;

    logic [NUM_SEGMENTS-1:0] seg;
    logic [IDX_W-1:0]        lowest;
    logic [POP_W-1:0]        pop;
    logic [POS_W-1:0]        pos;

    assign seg = i_active[NUM_KEYS +: NUM_SEGMENTS];

    always_comb begin
        for (int k = 0; k < ctks_pkg::KEYS_W; k++) begin
            o_keys[k] = (k < NUM_KEYS) ? i_active[k] : 1'b0;
        end
    end

    // pos = 2*lowest + (segments active); lower ones are idle by definition
    always_comb begin
        lowest = '0;
        pop    = '0;
        for (int i = NUM_SEGMENTS - 1; i >= 0; i--) begin
            if (seg[i]) begin
                lowest = IDX_W'(i);
            end
            pop = pop + POP_W'(seg[i]);
        end
        pos = (POS_W'(lowest) << 1) + POS_W'(pop);
    end

    assign o_slider = (seg != '0) ? pos[ctks_pkg::SLIDER_W-1:0] : '0;
endmodule

// File: sv/ctks_chk.sv
// Port-level checker for the touch unit, bound to the top level.
// Depends on ctks_pkg and cap_touch_keys_and_slider_unit.
module ctks_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic                          o_load_drive,
    input logic                          o_busy_res,
    input logic                          o_result_valid,
    input logic                          o_calib_done,
    input logic [ctks_pkg::KEYS_W-1:0]   o_key_flags,
    input logic [ctks_pkg::SLIDER_W-1:0] o_slider_pos
);
    // a scan ends either as measure or as calibrate, never both
    a_end_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_result_valid && o_calib_done))
        else $error("result and calibration flagged together");

    // a finished scan is no longer busy
    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_result_valid || o_calib_done)) |-> !o_busy_res)
        else $error("scan end reported while busy");

    // charging is part of a running scan
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_load_drive) |-> o_busy_res)
        else $error("load driven outside a scan");

    // key and slider fields are zero except on a measure result
    a_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_result_valid) |-> ((o_key_flags == '0) && (o_slider_pos == '0)))
        else $error("touch data outside a measure result");

    // stalled result word holds its touch fields, result flag and busy flag
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_key_flags) && $stable(o_slider_pos) &&
             $stable(o_result_valid) && $stable(o_busy_res)))
        else $error("stalled result word changed");
endmodule

bind cap_touch_keys_and_slider_unit ctks_chk u_ctks_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_load_drive   (o_load_drive),
    .o_busy_res     (o_busy_res),
    .o_result_valid (o_result_valid),
    .o_calib_done   (o_calib_done),
    .o_key_flags    (o_key_flags),
    .o_slider_pos   (o_slider_pos)
);
